// ----- hw/rtl/ljpf_pkg.sv -----
// Shared types and constants for the pair force accumulator.
`default_nettype none

package ljpf_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_PAIR  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_LD1,
        ST_LD2,
        ST_TBL,
        ST_DQ_GO,
        ST_DQ_WAIT,
        ST_DIR_GO,
        ST_DIR_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ACC_RDA,
        ST_ACC_WRA,
        ST_ACC_RDB,
        ST_ACC_WRB,
        ST_RC_RD,
        ST_RC_WR,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MOP_S2,
        MOP_S4,
        MOP_S6,
        MOP_S12,
        MOP_A,
        MOP_B,
        MOP_IR2,
        MOP_M,
        MOP_M2,
        MOP_FX,
        MOP_FY,
        MOP_FZ
    } mop_t;

    // right shift applied to the 128-bit product
    typedef enum logic [1:0] {
        SH16,
        SH23,
        SH24,
        SH32
    } shsel_t;

    typedef struct packed {
        logic   start;
        shsel_t sh;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_rsp_t;

    localparam logic [31:0] CUTOFF_RESET = 32'd786432;
    localparam logic [47:0] POS47        = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG47        = 48'h8000_0000_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/lj_pair_force_accumulator.sv -----
// Top level: Lennard-Jones 12-6 pair force and energy accumulator.
//
//  channel   dir  group                         contents
//  s_        in   s_tvalid/s_tready/s_tdata/    one request item (load, pair,
//                 s_tuser                       read-clear, clear total)
//  m_        out  m_tvalid/m_tready/m_tdata/    one result item per request
//                 m_tuser
//  cfg_      in   cfg_we/cfg_wdata              cutoff radius register
//
//  A pair item passes from accept through the table read, two divisions on
//  the shared divider (64 quotient steps each), twelve passes through the
//  shared 64x64 multiplier, the accumulator read and write for particle a
//  and then particle b, and the result state before the next ready. Load
//  items write the table twice, read items read and zero an accumulator.
//  After reset a clearing pass writes zero to every particle accumulator,
//  one entry a cycle, with s_tready low.
//  The result sits in an output register: a stalled m_ side still lets the
//  next item in, and holds the block only when a second result is ready.
`default_nettype none

module lj_pair_force_accumulator
    import ljpf_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_SPECIES   = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config: cutoff_radius
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    // input item
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata from bit 0: particle_a[10] particle_b[10] species_a[5] species_b[5]
    // distance[32] disp_x[32] disp_y[32] disp_z[32] well_depth[32]
    // min_radius[32], two zero pad bits
    input  wire logic [223:0] s_tdata,
    // tuser: req_type[2]
    input  wire logic [1:0]   s_tuser,
    // result item
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata from bit 0: force_x[48] force_y[48] force_z[48] energy_value[48]
    // total_energy[48]
    output logic [239:0]      m_tdata,
    // tuser from bit 0: within_cutoff saturated
    output logic [1:0]        m_tuser
);

    localparam int TDEPTH = MAX_SPECIES * MAX_SPECIES;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int PAW    = $clog2(MAX_PARTICLES);

    // ---------------- input field views ----------------
    req_t        in_req;
    logic [9:0]  in_pa;
    logic [9:0]  in_pb;
    logic [4:0]  in_sa;
    logic [4:0]  in_sb;
    logic [31:0] in_dist;
    logic        s_accept;
    logic        in_spec_ok;
    logic        in_pa_ok;
    logic        in_pair_ok;
    logic [31:0] cutoff_reg;

    assign in_req  = req_t'(s_tuser);
    assign in_pa   = s_tdata[9:0];
    assign in_pb   = s_tdata[19:10];
    assign in_sa   = s_tdata[24:20];
    assign in_sb   = s_tdata[29:25];
    assign in_dist = s_tdata[61:30];

    assign s_accept   = s_tvalid && s_tready;
    assign in_spec_ok = (32'(in_sa) < MAX_SPECIES) && (32'(in_sb) < MAX_SPECIES);
    assign in_pa_ok   = 32'(in_pa) < MAX_PARTICLES;
    assign in_pair_ok = in_spec_ok && in_pa_ok && (32'(in_pb) < MAX_PARTICLES) &&
                        (in_dist != 32'd0) && (in_dist < cutoff_reg);

    // ---------------- registers ----------------
    state_t             state_reg;
    state_t             state_next;
    mop_t               op_reg;
    logic [PAW-1:0]     clr_cnt_reg;
    logic               clr_last;

    logic [9:0]         pa_reg;
    logic [9:0]         pb_reg;
    logic [4:0]         sa_reg;
    logic [4:0]         sb_reg;
    logic [31:0]        dist_reg;
    logic [31:0]        dx_reg;
    logic [31:0]        dy_reg;
    logic [31:0]        dz_reg;
    logic [31:0]        wd_reg;
    logic [31:0]        mr_reg;

    logic [31:0]        eps_reg;
    logic [63:0]        q_reg;
    logic [63:0]        s2_reg;
    logic [63:0]        s4_reg;
    logic [63:0]        s6_reg;
    logic [63:0]        s12_reg;
    logic [63:0]        ir_reg;
    logic [63:0]        m_reg;
    logic [63:0]        g_reg;
    logic [47:0]        a_reg;
    logic [47:0]        b_reg;
    logic [47:0]        fx_reg;
    logic [47:0]        fy_reg;
    logic [47:0]        fz_reg;
    logic [47:0]        ev_reg;
    logic [47:0]        total_reg;
    logic               within_reg;
    logic               sat_reg;

    logic               m_tvalid_reg;
    logic [239:0]       m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic               out_free;

    // ---------------- memories ----------------
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [TAW-1:0]     idx_ab;
    logic [TAW-1:0]     idx_ba;
    logic [63:0]        tbl_rdata;

    logic               acc_we;
    logic [PAW-1:0]     acc_waddr;
    logic [PAW-1:0]     acc_raddr;
    logic [191:0]       acc_wdata;
    logic [191:0]       acc_rdata;

    // ---------------- shared units ----------------
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic [63:0]        mul_prod;

    logic               div_start;
    logic [63:0]        div_dividend;
    logic               div_done;
    logic [63:0]        div_quo;

    // ---------------- helpers ----------------
    // clamp to the positive 48-bit limit: {sat, value}
    function automatic logic [48:0] cap_pos(input logic [63:0] v);
        logic big;
        big = v > 64'(POS47);
        return {big, big ? POS47 : v[47:0]};
    endfunction

    // apply the sign of the force component and clamp: {sat, value}
    function automatic logic [48:0] fcomp(input logic [63:0] p, input logic neg);
        logic big;
        if (neg) begin
            big = p > 64'(NEG47);
            return {big, big ? NEG47 : (48'd0 - p[47:0])};
        end
        big = p > 64'(POS47);
        return {big, big ? POS47 : p[47:0]};
    endfunction

    // saturating 48-bit add or subtract: {sat, value}
    function automatic logic [48:0] clamp_acc(input logic [47:0] a,
                                              input logic [47:0] b,
                                              input logic sub);
        logic [48:0] s;
        s = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
        if (s[48] != s[47]) begin
            return {1'b1, s[48] ? NEG47 : POS47};
        end
        return {1'b0, s[47:0]};
    endfunction

    // magnitude of a signed Q16.16 displacement
    function automatic logic [63:0] dmag(input logic [31:0] v);
        return v[31] ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
    endfunction

    assign idx_ab   = TAW'(32'(sa_reg) * 32'(MAX_SPECIES) + 32'(sb_reg));
    assign idx_ba   = TAW'(32'(sb_reg) * 32'(MAX_SPECIES) + 32'(sa_reg));
    assign clr_last = (clr_cnt_reg == PAW'(MAX_PARTICLES - 1));
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- arithmetic on results ----------------
    logic        gneg;
    logic [63:0] dpot;
    logic [48:0] cap_c;
    logic [67:0] g68;
    logic        g_big;
    logic        dneg_sel;
    logic [48:0] fc_c;
    logic        op_sat;
    logic [47:0] ev_c;
    logic [47:0] half_c;
    logic        sub_b;
    logic [48:0] cx;
    logic [48:0] cy;
    logic [48:0] cz;
    logic [48:0] ce;
    logic [48:0] ct;

    always_comb begin
        gneg   = s12_reg < s6_reg;
        dpot   = gneg ? (s6_reg - s12_reg) : (s12_reg - s6_reg);
        cap_c  = cap_pos(mul_prod);
        g68    = ({4'd0, mul_prod} << 3) + ({4'd0, mul_prod} << 2);
        g_big  = |g68[67:64];
        case (op_reg)
            MOP_FX:  dneg_sel = dx_reg[31];
            MOP_FY:  dneg_sel = dy_reg[31];
            default: dneg_sel = dz_reg[31];
        endcase
        fc_c   = fcomp(mul_prod, gneg ^ dneg_sel);
        // clamp flag of the pass that just finished
        case (op_reg)
            MOP_A, MOP_B:           op_sat = cap_c[48];
            MOP_M2:                 op_sat = g_big;
            MOP_FX, MOP_FY, MOP_FZ: op_sat = fc_c[48];
            default:                op_sat = 1'b0;
        endcase
        ev_c   = a_reg - b_reg;
        half_c = {ev_reg[47], ev_reg[47:1]};
        sub_b  = (state_reg == ST_ACC_WRB);
        cx     = clamp_acc(acc_rdata[47:0],    fx_reg, sub_b);
        cy     = clamp_acc(acc_rdata[95:48],   fy_reg, sub_b);
        cz     = clamp_acc(acc_rdata[143:96],  fz_reg, sub_b);
        ce     = clamp_acc(acc_rdata[191:144], half_c, 1'b0);
        ct     = clamp_acc(total_reg, ev_reg, 1'b0);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = q_reg;
        mul_b = q_reg;
        case (op_reg)
            MOP_S2: begin
                mul_a = q_reg;
                mul_b = q_reg;
            end
            MOP_S4: begin
                mul_a = s2_reg;
                mul_b = s2_reg;
            end
            MOP_S6: begin
                mul_a = s4_reg;
                mul_b = s2_reg;
            end
            MOP_S12: begin
                mul_a = s6_reg;
                mul_b = s6_reg;
            end
            MOP_A: begin
                mul_a = 64'(eps_reg);
                mul_b = s12_reg;
            end
            MOP_B: begin
                mul_a = 64'(eps_reg);
                mul_b = s6_reg;
            end
            MOP_IR2: begin
                mul_a = ir_reg;
                mul_b = ir_reg;
            end
            MOP_M: begin
                mul_a = dpot;
                mul_b = ir_reg;
            end
            MOP_M2: begin
                mul_a = 64'(eps_reg);
                mul_b = m_reg;
            end
            MOP_FX: begin
                mul_a = g_reg;
                mul_b = dmag(dx_reg);
            end
            MOP_FY: begin
                mul_a = g_reg;
                mul_b = dmag(dy_reg);
            end
            MOP_FZ: begin
                mul_a = g_reg;
                mul_b = dmag(dz_reg);
            end
            default: begin
                mul_a = q_reg;
                mul_b = q_reg;
            end
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_req)
                        REQ_LOAD: state_next = in_spec_ok ? ST_LD1 : ST_DONE;
                        REQ_PAIR: state_next = in_pair_ok ? ST_TBL : ST_DONE;
                        REQ_READ: state_next = in_pa_ok ? ST_RC_RD : ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LD1:      state_next = ST_LD2;
            ST_LD2:      state_next = ST_DONE;
            ST_TBL:      state_next = ST_DQ_GO;
            ST_DQ_GO:    state_next = ST_DQ_WAIT;
            ST_DQ_WAIT:  if (div_done) state_next = ST_DIR_GO;
            ST_DIR_GO:   state_next = ST_DIR_WAIT;
            ST_DIR_WAIT: if (div_done) state_next = ST_MUL_GO;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = (op_reg == MOP_FZ) ? ST_ACC_RDA : ST_MUL_GO;
                end
            end
            ST_ACC_RDA:  state_next = ST_ACC_WRA;
            ST_ACC_WRA:  state_next = ST_ACC_RDB;
            ST_ACC_RDB:  state_next = ST_ACC_WRB;
            ST_ACC_WRB:  state_next = ST_DONE;
            ST_RC_RD:    state_next = ST_RC_WR;
            ST_RC_WR:    state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        s_tready     = 1'b0;
        tbl_we       = 1'b0;
        tbl_waddr    = idx_ab;
        acc_we       = 1'b0;
        acc_waddr    = PAW'(pa_reg);
        acc_raddr    = PAW'(pa_reg);
        acc_wdata    = '0;
        mul_req      = '{start: 1'b0, sh: SH32};
        div_start    = 1'b0;
        div_dividend = {tbl_rdata[63:32], 32'd0};
        case (state_reg)
            ST_CLR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg;
            end
            ST_IDLE: s_tready = 1'b1;
            ST_LD1:  tbl_we = 1'b1;
            ST_LD2: begin
                tbl_we    = 1'b1;
                tbl_waddr = idx_ba;
            end
            ST_DQ_GO: div_start = 1'b1;
            ST_DIR_GO: begin
                div_start    = 1'b1;
                div_dividend = 64'd1 << 48;
            end
            ST_MUL_GO: begin
                mul_req.start = 1'b1;
                case (op_reg)
                    MOP_A, MOP_FX, MOP_FY, MOP_FZ: mul_req.sh = SH24;
                    MOP_B:   mul_req.sh = SH23;
                    MOP_M2:  mul_req.sh = SH16;
                    default: mul_req.sh = SH32;
                endcase
            end
            ST_ACC_WRA: begin
                acc_we    = 1'b1;
                acc_wdata = {ce[47:0], cz[47:0], cy[47:0], cx[47:0]};
            end
            ST_ACC_RDB: acc_raddr = PAW'(pb_reg);
            ST_ACC_WRB: begin
                acc_we    = 1'b1;
                acc_waddr = PAW'(pb_reg);
                acc_wdata = {ce[47:0], cz[47:0], cy[47:0], cx[47:0]};
            end
            ST_RC_WR: acc_we = 1'b1;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            cutoff_reg   <= CUTOFF_RESET;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + PAW'(1);
            end
            if (cfg_we) begin
                cutoff_reg <= cfg_wdata;
            end
            // clear the running total, or add the pair energy
            if (s_accept && in_req == REQ_CLEAR) begin
                total_reg <= '0;
            end else if (state_reg == ST_ACC_WRB) begin
                total_reg <= ct[47:0];
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pa_reg     <= in_pa;
            pb_reg     <= in_pb;
            sa_reg     <= in_sa;
            sb_reg     <= in_sb;
            dist_reg   <= in_dist;
            dx_reg     <= s_tdata[93:62];
            dy_reg     <= s_tdata[125:94];
            dz_reg     <= s_tdata[157:126];
            wd_reg     <= s_tdata[189:158];
            mr_reg     <= s_tdata[221:190];
            fx_reg     <= '0;
            fy_reg     <= '0;
            fz_reg     <= '0;
            ev_reg     <= '0;
            within_reg <= 1'b0;
            sat_reg    <= 1'b0;
        end
        case (state_reg)
            ST_DQ_GO: eps_reg <= tbl_rdata[31:0];
            ST_DQ_WAIT: if (div_done) q_reg <= div_quo;
            ST_DIR_WAIT: begin
                if (div_done) begin
                    ir_reg <= div_quo;
                    op_reg <= MOP_S2;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    op_reg  <= mop_t'(op_reg + 4'd1);
                    sat_reg <= sat_reg | mul_rsp.sat | op_sat;
                    case (op_reg)
                        MOP_S2:  s2_reg  <= mul_prod;
                        MOP_S4:  s4_reg  <= mul_prod;
                        MOP_S6:  s6_reg  <= mul_prod;
                        MOP_S12: s12_reg <= mul_prod;
                        MOP_A:   a_reg   <= cap_c[47:0];
                        MOP_B:   b_reg   <= cap_c[47:0];
                        MOP_IR2: ir_reg  <= mul_prod;
                        MOP_M:   m_reg   <= mul_prod;
                        MOP_M2:  g_reg   <= g_big ? '1 : g68[63:0];
                        MOP_FX:  fx_reg  <= fc_c[47:0];
                        MOP_FY:  fy_reg  <= fc_c[47:0];
                        default: fz_reg  <= fc_c[47:0];
                    endcase
                end
            end
            ST_ACC_RDA: ev_reg <= ev_c;
            ST_ACC_WRA: sat_reg <= sat_reg | cx[48] | cy[48] | cz[48] | ce[48];
            ST_ACC_WRB: begin
                sat_reg    <= sat_reg | cx[48] | cy[48] | cz[48] | ce[48] | ct[48];
                within_reg <= 1'b1;
            end
            ST_RC_WR: begin
                // return the accumulators; the write port zeroes them
                fx_reg <= acc_rdata[47:0];
                fy_reg <= acc_rdata[95:48];
                fz_reg <= acc_rdata[143:96];
                ev_reg <= acc_rdata[191:144];
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {total_reg, ev_reg, fz_reg, fy_reg, fx_reg};
            m_tuser_reg <= {sat_reg, within_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- instances ----------------
    // eps in the low word, Rmin in the high word
    ljpf_ram #(
        .WIDTH (64),
        .DEPTH (TDEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({mr_reg, wd_reg}),
        .raddr (idx_ab),
        .rdata (tbl_rdata)
    );

    // per particle: {energy, fz, fy, fx}
    ljpf_ram #(
        .WIDTH (192),
        .DEPTH (MAX_PARTICLES)
    ) u_acc (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    ljpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dist_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    ljpf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .rsp     (mul_rsp),
        .prod    (mul_prod)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ljpf_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ljpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ljpf_div.sv -----
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`default_nettype none

module ljpf_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        run_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        qbit;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[63]};
        rem_sub = rem_sh - {1'b0, divisor};
        qbit    = (rem_sh >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (run_reg) begin
            rem_reg <= qbit ? rem_sub[31:0] : rem_sh[31:0];
            quo_reg <= {quo_reg[62:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ljpf_mul.sv -----
// 64x64 multiplier over four 32x32 partial products, with shift and saturation.
`default_nettype none

module ljpf_mul
    import ljpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mul_req_t    req,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output mul_rsp_t         rsp,
    output logic [63:0]      prod
);

    logic         run_reg;
    logic         done_reg;
    logic         ppv_reg;
    logic [2:0]   cnt_reg;
    logic [1:0]   pk_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    shsel_t       sh_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shift;
    logic         sat_c;
    logic [63:0]  res_c;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        case (2'(pk_reg[1]) + 2'(pk_reg[0]))
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                ppv_reg <= 1'b0;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                ppv_reg <= (cnt_reg != 3'd4);
                if (cnt_reg == 3'd4) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            sh_reg  <= req.sh;
            acc_reg <= '0;
        end else if (run_reg) begin
            pp_reg <= 64'(a_half) * 64'(b_half);
            pk_reg <= cnt_reg[1:0];
            if (ppv_reg) begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    // overflow above 64 bits after the shift clamps to all ones
    always_comb begin
        case (sh_reg)
            SH16: begin
                sat_c = |acc_reg[127:80];
                res_c = acc_reg[79:16];
            end
            SH23: begin
                sat_c = |acc_reg[127:87];
                res_c = acc_reg[86:23];
            end
            SH24: begin
                sat_c = |acc_reg[127:88];
                res_c = acc_reg[87:24];
            end
            default: begin
                sat_c = |acc_reg[127:96];
                res_c = acc_reg[95:32];
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_c;
    assign prod     = sat_c ? '1 : res_c;

endmodule

`default_nettype wire

// ----- hw/rtl/ljpf_checker.sv -----
// Port-level checks for the pair force accumulator, bound to the top level.
`default_nettype none

module ljpf_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [239:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset starts the clearing pass with nothing offered
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block open right after reset");

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind lj_pair_force_accumulator ljpf_checker u_ljpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
